// ===== rtl/core/fdf_pkg.sv =====
// shared types and constants for the flooding duplicate filter
`timescale 1ns / 1ps

package fdf_pkg;

    // fixed field widths of the message header and the configuration port
    localparam int MSG_ID_W    = 64;
    localparam int ADDR_W      = 16;
    localparam int HOP_W       = 8;
    localparam int ACTION_W    = 2;
    localparam int TDATA_W     = 88;
    localparam int S_TUSER_W   = 2;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 2;

    // message origin codes
    localparam logic OP_RECEIVED = 1'b0;
    localparam logic OP_LOCAL    = 1'b1;

    // register byte addresses
    localparam logic [APB_ADDR_W-1:0] REG_NODE_ADDRESS = 2'd0;

    // routing decision codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_MALFORMED = 2'd0,
        ACT_DUPLICATE = 2'd1,
        ACT_DELIVER   = 2'd2,
        ACT_FORWARD   = 2'd3
    } action_t;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

// ===== rtl/core/flood_duplicate_filter_core.sv =====
// Duplicate suppression and routing decision for one node of a flooding mesh.
// Each transaction on the s_ side is one message header and yields exactly one
// transaction on the m_ side. Recent message ids sit in a ring memory of
// CACHE_DEPTH entries with a registered read port; the ring fills in order from
// entry zero, so a fill count marks which entries hold ids. A well-formed
// received message is checked by reading the stored ids one per cycle and
// comparing each against its id; the walk stops at the first match. A locally
// created or malformed header, or a received one while the ring is empty, goes
// straight to the decision step. The next header is accepted in the idle state,
// which the sequencer enters as the result is registered. One header is
// processed at a time; a result left waiting in the output register blocks
// only the final step of the next header, which registers its result and
// stores its id. Configuration: node_address at byte address 0; the user
// must write it only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps

module flood_duplicate_filter_core
    import fdf_pkg::*;
#(
    parameter int CACHE_DEPTH = 32,
    parameter int ID_WIDTH    = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // message headers in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // message_id [63:0], dest_address [79:64], hop_count [87:80]
    input  logic [TDATA_W-1:0]    s_tdata,
    // opcode [0], header_ok [1]
    input  logic [S_TUSER_W-1:0]  s_tuser,

    // routing results out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_message_id [63:0], out_dest_address [79:64], out_hop_count [87:80]
    output logic [TDATA_W-1:0]    m_tdata,
    // action [1:0]
    output logic [ACTION_W-1:0]   m_tuser,

    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(CACHE_DEPTH);
    localparam int CW = $clog2(CACHE_DEPTH + 1);

    // ring memory of recent ids
    logic [ID_WIDTH-1:0] id_mem [CACHE_DEPTH];

    state_t              state_reg, state_next;
    logic [ID_WIDTH-1:0] id_reg, id_next;
    logic [ADDR_W-1:0]   dest_reg, dest_next;
    logic [HOP_W-1:0]    hop_reg, hop_next;
    logic                malformed_reg, malformed_next;
    logic                dup_reg, dup_next;
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [CW-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [ID_WIDTH-1:0] rd_data_reg;
    logic [ADDR_W-1:0]   node_addr_reg;

    logic                m_tvalid_reg, m_tvalid_next;
    action_t             m_action_reg, m_action_next;
    logic [MSG_ID_W-1:0] m_id_reg, m_id_next;
    logic [ADDR_W-1:0]   m_dest_reg, m_dest_next;
    logic [HOP_W-1:0]    m_hop_reg, m_hop_next;

    logic                s_accept;
    logic                out_free;
    logic                rd_en;
    logic                hit;
    logic                mem_we;
    logic                cfg_we;
    logic                in_opcode;
    logic                in_ok;
    action_t             action;
    logic [HOP_W-1:0]    hop_inc;

    assign in_opcode = s_tuser[0];
    assign in_ok     = s_tuser[1];
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // compare the id read last cycle
    assign hit   = rd_pend_reg && (rd_data_reg == id_reg);
    assign rd_en = (state_reg == ST_SCAN) && (rd_cnt_reg < fill_reg) && !hit;

    // routing decision for the held header
    assign hop_inc = (hop_reg == {HOP_W{1'b1}}) ? hop_reg : hop_reg + HOP_W'(1);
    always_comb begin
        if (malformed_reg) begin
            action = ACT_MALFORMED;
        end else if (dup_reg) begin
            action = ACT_DUPLICATE;
        end else if (dest_reg == node_addr_reg) begin
            action = ACT_DELIVER;
        end else begin
            action = ACT_FORWARD;
        end
    end

    assign mem_we = (state_reg == ST_DONE) && out_free && !malformed_reg && !dup_reg;

    // sequencer and output register next state
    always_comb begin
        state_next     = state_reg;
        id_next        = id_reg;
        dest_next      = dest_reg;
        hop_next       = hop_reg;
        malformed_next = malformed_reg;
        dup_next       = dup_reg;
        wr_ptr_next    = wr_ptr_reg;
        fill_next      = fill_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_pend_next   = 1'b0;
        m_tvalid_next  = m_tvalid_reg;
        m_action_next  = m_action_reg;
        m_id_next      = m_id_reg;
        m_dest_next    = m_dest_reg;
        m_hop_next     = m_hop_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    id_next        = s_tdata[ID_WIDTH-1:0];
                    dest_next      = s_tdata[MSG_ID_W +: ADDR_W];
                    hop_next       = s_tdata[MSG_ID_W+ADDR_W +: HOP_W];
                    malformed_next = (in_opcode == OP_RECEIVED) && !in_ok;
                    dup_next       = 1'b0;
                    rd_cnt_next    = '0;
                    if ((in_opcode == OP_RECEIVED) && in_ok && (fill_reg != '0)) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    dup_next   = 1'b1;
                    state_next = ST_DONE;
                end else if (rd_en) begin
                    rd_cnt_next  = rd_cnt_reg + CW'(1);
                    rd_pend_next = 1'b1;
                end else if (!rd_pend_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_action_next = action;
                    m_id_next     = MSG_ID_W'(id_reg);
                    m_dest_next   = dest_reg;
                    m_hop_next    = (action == ACT_FORWARD) ? hop_inc : hop_reg;
                    if (mem_we) begin
                        if (wr_ptr_reg == AW'(CACHE_DEPTH - 1)) begin
                            wr_ptr_next = '0;
                        end else begin
                            wr_ptr_next = wr_ptr_reg + AW'(1);
                        end
                        if (fill_reg != CW'(CACHE_DEPTH)) begin
                            fill_next = fill_reg + CW'(1);
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            rd_cnt_reg   <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wr_ptr_reg   <= wr_ptr_next;
            fill_reg     <= fill_next;
            rd_cnt_reg   <= rd_cnt_next;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // header and result payload
    always_ff @(posedge aclk) begin
        id_reg        <= id_next;
        dest_reg      <= dest_next;
        hop_reg       <= hop_next;
        malformed_reg <= malformed_next;
        dup_reg       <= dup_next;
        m_action_reg  <= m_action_next;
        m_id_reg      <= m_id_next;
        m_dest_reg    <= m_dest_next;
        m_hop_reg     <= m_hop_next;
    end

    // id ring memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            id_mem[wr_ptr_reg] <= id_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= id_mem[rd_cnt_reg[AW-1:0]];
        end
    end

    // configuration register
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_addr_reg <= '0;
        end else if (cfg_we && (paddr == REG_NODE_ADDRESS)) begin
            node_addr_reg <= pwdata[ADDR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_NODE_ADDRESS) ? APB_DATA_W'(node_addr_reg) : '0;

    // result channel
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_hop_reg, m_dest_reg, m_id_reg};
    assign m_tuser  = m_action_reg;

`ifndef SYNTHESIS
    // a new result only comes out of the decision step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside decision step");

    // the ring never counts more ids than it holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(CACHE_DEPTH))
        else $error("fill count beyond ring depth");

    // dropped headers leave the ring untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (malformed_reg || dup_reg)) |=>
            $stable(fill_reg) && $stable(wr_ptr_reg))
        else $error("dropped header changed the ring");

    // a match is only seen while walking the ring
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> $past(state_reg == ST_SCAN))
        else $error("ring read outside the walk");
`endif

endmodule

// ===== sim/flood_duplicate_filter_core_test.sv =====
// testbench for the flooding duplicate filter core with a self-checking routing predictor
`timescale 1ns / 1ps

module flood_duplicate_filter_core_test
    import fdf_pkg::*;
();

    localparam int CACHE_DEPTH  = 32;
    localparam int ID_WIDTH     = 64;
    localparam int ITEMS_PHASE  = 150;
    localparam int PHASES       = 5;
    localparam int POOL_SIZE    = 40;
    localparam int MAX_GAP      = 18;
    localparam logic [63:0] ID_MASK = {64{1'b1}} >> (64 - ID_WIDTH);

    // one message header as it enters the block
    typedef struct packed {
        logic                  opcode;
        logic                  header_ok;
        logic [MSG_ID_W-1:0]   msg_id;
        logic [ADDR_W-1:0]     dest;
        logic [HOP_W-1:0]      hop;
    } header_t;

    // one routing decision as it leaves the block
    typedef struct packed {
        action_t               action;
        logic [MSG_ID_W-1:0]   msg_id;
        logic [ADDR_W-1:0]     dest;
        logic [HOP_W-1:0]      hop;
    } route_t;

    // directed row: header plus an optional hand-written decision
    typedef struct packed {
        header_t hdr;
        logic    typed;
        route_t  res;
    } directed_row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [ACTION_W-1:0]   m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    flood_duplicate_filter_core #(
        .CACHE_DEPTH(CACHE_DEPTH),
        .ID_WIDTH   (ID_WIDTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 aclk = ~aclk;

    // predictor state: recent id ring, valid bits, ring pointer, node address
    logic [MSG_ID_W-1:0] seen_ids   [CACHE_DEPTH];
    logic                seen_valid [CACHE_DEPTH];
    int unsigned         ring_ptr = 0;
    logic [ADDR_W-1:0]   node_addr_model = '0;

    route_t        pending_routes[$];
    directed_row_t directed_rows[$];
    logic [63:0]   id_pool[POOL_SIZE];
    int unsigned   errors = 0;
    int unsigned   headers_sent = 0;
    int unsigned   routes_checked = 0;
    int unsigned   action_count[4] = '{0, 0, 0, 0};
    int unsigned   src_calm = 0;
    int unsigned   sink_calm = 0;

    initial begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            seen_valid[i] = 1'b0;
            seen_ids[i]   = '0;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // duplicate check, ring store and routing decision for one accepted header
    function automatic route_t route_header(input header_t hdr);
        route_t r;
        logic   dup;
        r.msg_id = hdr.msg_id & ID_MASK;
        r.dest   = hdr.dest;
        r.hop    = hdr.hop;
        dup = 1'b0;
        for (int i = 0; i < CACHE_DEPTH; i++)
            if (seen_valid[i] && seen_ids[i] == r.msg_id)
                dup = 1'b1;
        if (hdr.opcode == OP_RECEIVED && !hdr.header_ok) begin
            r.action = ACT_MALFORMED;
        end else if (hdr.opcode == OP_RECEIVED && dup) begin
            r.action = ACT_DUPLICATE;
        end else begin
            seen_ids[ring_ptr]   = r.msg_id;
            seen_valid[ring_ptr] = 1'b1;
            ring_ptr = (ring_ptr + 1) % CACHE_DEPTH;
            if (hdr.dest == node_addr_model) begin
                r.action = ACT_DELIVER;
            end else begin
                r.action = ACT_FORWARD;
                if (hdr.hop != 8'hFF)
                    r.hop = hdr.hop + 8'd1;
            end
        end
        return r;
    endfunction

    // idle length per transaction, with occasional runs of back-to-back traffic
    function automatic int unsigned draw_gap(inout int unsigned calm);
        if (calm == 0 && $urandom_range(0, 7) == 0)
            calm = $urandom_range(10, 30);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic directed_row_t row(input logic op, input logic ok,
                                          input logic [63:0] id, input logic [15:0] dest,
                                          input logic [7:0] hop, input logic typed,
                                          input action_t act, input logic [7:0] out_hop);
        directed_row_t d;
        d.hdr   = '{op, ok, id, dest, hop};
        d.typed = typed;
        d.res   = '{act, id, dest, out_hop};
        return d;
    endfunction

    // send one header, then record its expected decision on acceptance
    task automatic send_header(input header_t hdr, input logic typed, input route_t typed_res);
        int unsigned gap;
        route_t      predicted;
        gap = draw_gap(src_calm);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hdr.hop, hdr.dest, hdr.msg_id};
        s_tuser  <= {hdr.header_ok, hdr.opcode};
        do @(posedge aclk); while (!s_tready);
        predicted = route_header(hdr);
        pending_routes.push_back(typed ? typed_res : predicted);
        headers_sent++;
    endtask

    // apb write of node_address followed by a read back
    task automatic write_node_address(input logic [ADDR_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_NODE_ADDRESS;
        pwdata  <= {{(APB_DATA_W-ADDR_W){1'b0}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        node_addr_model = value;
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {{(APB_DATA_W-ADDR_W){1'b0}}, value})
            report_mismatch("node_address read back", 64'(prdata), 64'(value));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_routes.size() != 0) @(posedge aclk);
        repeat (CACHE_DEPTH + 8) @(posedge aclk);
    endtask

    function automatic header_t random_header();
        header_t     h;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        h.opcode    = (pick >= 8 && pick < 20) ? OP_LOCAL : OP_RECEIVED;
        h.header_ok = (pick < 8) ? 1'b0 : (h.opcode == OP_LOCAL) ? 1'($urandom) : 1'b1;
        if ($urandom_range(0, 99) < 60)
            h.msg_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            h.msg_id = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 30)      h.dest = node_addr_model;
        else if (pick < 40) h.dest = 16'h0000;
        else if (pick < 50) h.dest = 16'hFFFF;
        else                h.dest = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10)      h.hop = 8'hFF;
        else if (pick < 20) h.hop = 8'hFE;
        else if (pick < 25) h.hop = 8'h00;
        else                h.hop = 8'($urandom);
        return h;
    endfunction

    // result side backpressure
    initial begin
        int unsigned stall;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            stall = draw_gap(sink_calm);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // compare each routing result with the oldest expectation
    always @(posedge aclk) begin
        route_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_routes.size() == 0) begin
                report_mismatch("unexpected result tdata", m_tdata[63:0], '0);
            end else begin
                want = pending_routes.pop_front();
                routes_checked++;
                action_count[want.action]++;
                if (m_tuser !== want.action)
                    report_mismatch("action", 64'(m_tuser), 64'(want.action));
                if (m_tdata[63:0] !== want.msg_id)
                    report_mismatch("out_message_id", m_tdata[63:0], want.msg_id);
                if (m_tdata[79:64] !== want.dest)
                    report_mismatch("out_dest_address", 64'(m_tdata[79:64]),
                                    64'(want.dest));
                if (m_tdata[87:80] !== want.hop)
                    report_mismatch("out_hop_count", 64'(m_tdata[87:80]), 64'(want.hop));
            end
        end
    end

    // run limit
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // reset, directed headers, then random phases over several node addresses
    initial begin
        logic [ADDR_W-1:0] setting;
        header_t           hdr;
        route_t            none;
        none = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            id_pool[i] = {$urandom, $urandom};
        id_pool[0] = '0;
        id_pool[1] = '1;

        // node address is zero out of reset
        directed_rows.push_back(row(OP_RECEIVED, 1'b0, '1, 16'hFFFF, 8'hFF, 1'b1,
                                    ACT_MALFORMED, 8'hFF));
        directed_rows.push_back(row(OP_RECEIVED, 1'b1, 64'd1, 16'h0000, 8'h00, 1'b1,
                                    ACT_DELIVER, 8'h00));
        directed_rows.push_back(row(OP_RECEIVED, 1'b1, 64'd1, 16'h0007, 8'h03, 1'b1,
                                    ACT_DUPLICATE, 8'h03));
        // id zero is new here, hop saturates on forward
        directed_rows.push_back(row(OP_RECEIVED, 1'b1, 64'd0, 16'h0001, 8'hFF, 1'b1,
                                    ACT_FORWARD, 8'hFF));
        directed_rows.push_back(row(OP_RECEIVED, 1'b1, 64'd0, 16'h0000, 8'h09, 1'b1,
                                    ACT_DUPLICATE, 8'h09));
        // local with bad header and a known id is still stored and routed
        directed_rows.push_back(row(OP_LOCAL, 1'b0, 64'd1, 16'h0005, 8'h07, 1'b1,
                                    ACT_FORWARD, 8'h08));
        directed_rows.push_back(row(OP_LOCAL, 1'b1, '1, 16'hFFFF, 8'hFE, 1'b1,
                                    ACT_FORWARD, 8'hFF));
        directed_rows.push_back(row(OP_RECEIVED, 1'b1, '1, 16'h0000, 8'h00, 1'b1,
                                    ACT_DUPLICATE, 8'h00));
        // malformed wins over a duplicate id
        directed_rows.push_back(row(OP_RECEIVED, 1'b0, 64'd1, 16'h0000, 8'h00, 1'b1,
                                    ACT_MALFORMED, 8'h00));
        directed_rows.push_back(row(OP_LOCAL, 1'b1, 64'd0, 16'h0000, 8'h00, 1'b1,
                                    ACT_DELIVER, 8'h00));
        // alternating bit patterns through every field
        directed_rows.push_back(row(OP_RECEIVED, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555,
                                    8'hAA, 1'b0, ACT_MALFORMED, 8'h00));
        directed_rows.push_back(row(OP_RECEIVED, 1'b1, 64'h5555_5555_5555_5555, 16'hAAAA,
                                    8'h55, 1'b0, ACT_MALFORMED, 8'h00));
        directed_rows.push_back(row(OP_RECEIVED, 1'b1, 64'h8000_0000_0000_0000, 16'h8000,
                                    8'h80, 1'b0, ACT_MALFORMED, 8'h00));
        directed_rows.push_back(row(OP_LOCAL, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 16'h0000,
                                    8'hFF, 1'b0, ACT_MALFORMED, 8'h00));
        directed_rows.push_back(row(OP_RECEIVED, 1'b1, 64'h5555_5555_5555_5555, 16'h0000,
                                    8'h01, 1'b0, ACT_MALFORMED, 8'h00));

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_header(directed_rows[i].hdr, directed_rows[i].typed, directed_rows[i].res);

        for (int phase = 0; phase < PHASES; phase++) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            wait_idle();
            case (phase)
                0: setting = 16'hFFFF;
                2: setting = 16'h0000;
                4: setting = 16'h0001;
                default: setting = 16'($urandom);
            endcase
            write_node_address(setting);
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                hdr = random_header();
                send_header(hdr, 1'b0, none);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (pending_routes.size() != 0) @(posedge aclk);
        repeat (CACHE_DEPTH + 8) @(posedge aclk);

        $display("%0d headers sent and %0d routing results checked over %0d node addresses",
                 headers_sent, routes_checked, PHASES + 1);
        $display("malformed %0d, duplicate %0d, delivered %0d, forwarded %0d",
                 action_count[0], action_count[1], action_count[2], action_count[3]);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/fdf_pkg.sv
rtl/core/flood_duplicate_filter_core.sv
sim/flood_duplicate_filter_core_test.sv
